// File: rtl/cascaded_pd_attitude_altitude_control_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded PD autopilot
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CASCADED_PD_ATTITUDE_ALTITUDE_CONTROL_TOP_DEFINES_SVH
`define CASCADED_PD_ATTITUDE_ALTITUDE_CONTROL_TOP_DEFINES_SVH

// same-cycle implication
`define CPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared constants and types of the cascaded PD autopilot.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // Q3.12 angle constants
  localparam int PI_Q12          = 12868;
  localparam int TWO_PI_Q12      = 25736;
  localparam int PITCH_LIMIT_Q12 = 3574;
  // Q1.14 full scale
  localparam int SERVO_ONE       = 16384;

  localparam int NUM_REGS = 8;

  // default tuning
  localparam int ELEV_OFFSET_DEF     = 0;
  localparam int AIL_OFFSET_DEF      = 0;
  localparam int ROLL_LIMIT_DEG_DEF  = 45;
  localparam int INVERT_ELEVATOR_DEF = 1;
  localparam int INVERT_AILERON_DEF  = 1;

  // register indexes
  typedef enum logic [2:0] {
    REG_ALT_P     = 3'd0,
    REG_ALT_D     = 3'd1,
    REG_PITCH_P   = 3'd2,
    REG_PITCH_D   = 3'd3,
    REG_HEADING_P = 3'd4,
    REG_HEADING_D = 3'd5,
    REG_ROLL_P    = 3'd6,
    REG_ROLL_D    = 3'd7
  } reg_idx_e;

  // stage advance strobes of the servo back end
  typedef struct packed {
    logic diff;
    logic mult;
    logic sum;
  } servo_en_t;

endpackage

// File: rtl/cascaded_pd_attitude_altitude_control_top.sv
// ----------------------------------------------------------------------------
// cascaded_pd_attitude_altitude_control_top
// Cascaded PD autopilot: altitude->pitch->elevator, heading->roll->aileron.
// ----------------------------------------------------------------------------
// Throughput: 1 request/cycle while no stall backs up to s_axis_tready_o.
// Six register stages, each about one 16x17 multiply or one wide add/clamp.
// Stalls back up stage by stage; empty stages keep filling while output waits.
// Reset clears stage valid bits and all gain registers to zero.
// ----------------------------------------------------------------------------
`include "cascaded_pd_attitude_altitude_control_top_defines.svh"

module cascaded_pd_attitude_altitude_control_top #(
  parameter int ELEV_OFFSET     = cpd_pkg::ELEV_OFFSET_DEF,
  parameter int AIL_OFFSET      = cpd_pkg::AIL_OFFSET_DEF,
  parameter int ROLL_LIMIT_DEG  = cpd_pkg::ROLL_LIMIT_DEG_DEF,
  parameter int INVERT_ELEVATOR = cpd_pkg::INVERT_ELEVATOR_DEF,
  parameter int INVERT_AILERON  = cpd_pkg::INVERT_AILERON_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // gain registers
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  // sample requests
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // altitude_target, altitude_now, down_speed, pitch_now, pitch_rate_now,
  // heading_target, heading_now, yaw_rate_now, roll_now, roll_rate_now
  // (16 bits each, lowest first)
  input  logic [159:0]  s_axis_tdata_i,
  // results
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // elevator_cmd [15:0], aileron_cmd [31:16], pitch_setpoint [44:32],
  // roll_setpoint [58:45], zero [63:59]
  output logic [63:0]   m_axis_tdata_o
);

  localparam int NumStages = 6;
  // roll clamp in Q3.12, rounded from degrees
  localparam logic signed [34:0] RollLim =
    35'((ROLL_LIMIT_DEG * cpd_pkg::PI_Q12 + 90) / 180);

  // --------------------------------------------------------------------------
  // Gain registers
  // --------------------------------------------------------------------------
  logic signed [15:0] gain_q [cpd_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cpd_pkg::NUM_REGS; i++) gain_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < 4'(cpd_pkg::NUM_REGS))) begin
      gain_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage control: a stage takes new data when empty or when it drains
  // --------------------------------------------------------------------------
  logic [NumStages:1] valid_q;
  logic [NumStages:1] adv;
  logic               s_fire;

  always_comb begin
    adv[NumStages] = !valid_q[NumStages] || m_axis_tready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[1]) valid_q[1] <= s_axis_tvalid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = adv[1];
  assign m_axis_tvalid_o = valid_q[NumStages];
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Request unpack
  // --------------------------------------------------------------------------
  logic signed [15:0] alt_t, alt_n, vdown, pitch_in, prate_in;
  logic signed [15:0] hdg_t, hdg_n, yrate_in, roll_in, rrate_in;

  assign alt_t    = s_axis_tdata_i[15:0];
  assign alt_n    = s_axis_tdata_i[31:16];
  assign vdown    = s_axis_tdata_i[47:32];
  assign pitch_in = s_axis_tdata_i[63:48];
  assign prate_in = s_axis_tdata_i[79:64];
  assign hdg_t    = s_axis_tdata_i[95:80];
  assign hdg_n    = s_axis_tdata_i[111:96];
  assign yrate_in = s_axis_tdata_i[127:112];
  assign roll_in  = s_axis_tdata_i[143:128];
  assign rrate_in = s_axis_tdata_i[159:144];

  // --------------------------------------------------------------------------
  // Stage 1: errors; heading error wrapped a single time
  // --------------------------------------------------------------------------
  logic signed [16:0] herr_raw, herr_wrap;
  logic signed [16:0] alt_diff_q, herr_q;
  logic signed [15:0] vdown_q, prate_q, yrate_q, rrate_q, pitch1_q, roll1_q;

  always_comb begin
    herr_raw = 17'(hdg_t) - 17'(hdg_n);
    if (herr_raw >= 17'(cpd_pkg::PI_Q12)) begin
      herr_wrap = herr_raw - 17'(cpd_pkg::TWO_PI_Q12);
    end else if (herr_raw <= -17'(cpd_pkg::PI_Q12)) begin
      herr_wrap = herr_raw + 17'(cpd_pkg::TWO_PI_Q12);
    end else begin
      herr_wrap = herr_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      alt_diff_q <= 17'(alt_t) - 17'(alt_n);
      herr_q     <= herr_wrap;
      vdown_q    <= vdown;
      prate_q    <= prate_in;
      yrate_q    <= yrate_in;
      rrate_q    <= rrate_in;
      pitch1_q   <= pitch_in;
      roll1_q    <= roll_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: outer-loop products and inner-loop damping products
  // --------------------------------------------------------------------------
  logic signed [32:0] p_alt_q, p_hd_q;
  logic signed [31:0] p_vd_q, p_yr_q, p_pr_q, p_rr_q;
  logic signed [15:0] pitch2_q, roll2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      p_alt_q  <= 33'(gain_q[cpd_pkg::REG_ALT_P]) * 33'(alt_diff_q);
      p_vd_q   <= 32'(gain_q[cpd_pkg::REG_ALT_D]) * 32'(vdown_q);
      p_hd_q   <= 33'(gain_q[cpd_pkg::REG_HEADING_P]) * 33'(herr_q);
      p_yr_q   <= 32'(gain_q[cpd_pkg::REG_HEADING_D]) * 32'(yrate_q);
      p_pr_q   <= 32'(gain_q[cpd_pkg::REG_PITCH_D]) * 32'(prate_q);
      p_rr_q   <= 32'(gain_q[cpd_pkg::REG_ROLL_D]) * 32'(rrate_q);
      pitch2_q <= pitch1_q;
      roll2_q  <= roll1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: setpoints, round half up, clamp
  // --------------------------------------------------------------------------
  logic signed [37:0] acc_p, sh_p;
  logic signed [34:0] acc_r, sh_r;
  logic signed [12:0] psp_d;
  logic signed [13:0] rsp_d;
  logic signed [13:0] psp_q, rsp_q;
  logic signed [31:0] p_pr3_q, p_rr3_q;
  logic signed [15:0] pitch3_q, roll3_q;

  assign acc_p = (38'(p_alt_q) <<< 4) + 38'(p_vd_q) + 38'sd8;
  assign sh_p  = acc_p >>> 4;
  assign acc_r = 35'(p_hd_q) - 35'(p_yr_q) + 35'sd128;
  assign sh_r  = acc_r >>> 8;

  always_comb begin
    if (sh_p > 38'(cpd_pkg::PITCH_LIMIT_Q12)) begin
      psp_d = 13'(cpd_pkg::PITCH_LIMIT_Q12);
    end else if (sh_p < -38'(cpd_pkg::PITCH_LIMIT_Q12)) begin
      psp_d = -13'(cpd_pkg::PITCH_LIMIT_Q12);
    end else begin
      psp_d = sh_p[12:0];
    end
    if (sh_r > RollLim) begin
      rsp_d = RollLim[13:0];
    end else if (sh_r < -RollLim) begin
      rsp_d = 14'(-RollLim);
    end else begin
      rsp_d = sh_r[13:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      psp_q    <= 14'(psp_d);
      rsp_q    <= rsp_d;
      p_pr3_q  <= p_pr_q;
      p_rr3_q  <= p_rr_q;
      pitch3_q <= pitch2_q;
      roll3_q  <= roll2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4-6: inner loops
  // --------------------------------------------------------------------------
  cpd_pkg::servo_en_t servo_en;
  logic signed [15:0] elev_cmd, ail_cmd;
  logic signed [13:0] psp_out_w, rsp_out;
  logic signed [12:0] psp_out;

  assign servo_en.diff = adv[4];
  assign servo_en.mult = adv[5];
  assign servo_en.sum  = adv[6];

  cpd_servo #(
    .TRIM   (ELEV_OFFSET),
    .INVERT (INVERT_ELEVATOR)
  ) u_elevator (
    .clk_i    (clk_i),
    .en_i     (servo_en),
    .sp_i     (psp_q),
    .meas_i   (pitch3_q),
    .kp_i     (gain_q[cpd_pkg::REG_PITCH_P]),
    .d_prod_i (p_pr3_q),
    .cmd_o    (elev_cmd),
    .sp_o     (psp_out_w)
  );

  cpd_servo #(
    .TRIM   (AIL_OFFSET),
    .INVERT (INVERT_AILERON)
  ) u_aileron (
    .clk_i    (clk_i),
    .en_i     (servo_en),
    .sp_i     (rsp_q),
    .meas_i   (roll3_q),
    .kp_i     (gain_q[cpd_pkg::REG_ROLL_P]),
    .d_prod_i (p_rr3_q),
    .cmd_o    (ail_cmd),
    .sp_o     (rsp_out)
  );

  assign psp_out        = psp_out_w[12:0];
  assign m_axis_tdata_o = {5'b0, rsp_out, psp_out, ail_cmd, elev_cmd};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic psp_ok, rsp_ok, cmd_ok;

  assign psp_ok = (psp_out <= 13'(cpd_pkg::PITCH_LIMIT_Q12)) &&
                  (psp_out >= -13'(cpd_pkg::PITCH_LIMIT_Q12));
  assign rsp_ok = (35'(rsp_out) <= RollLim) && (35'(rsp_out) >= -RollLim);
  assign cmd_ok = (elev_cmd <= 16'(cpd_pkg::SERVO_ONE)) &&
                  (elev_cmd >= -16'(cpd_pkg::SERVO_ONE)) &&
                  (ail_cmd <= 16'(cpd_pkg::SERVO_ONE)) &&
                  (ail_cmd >= -16'(cpd_pkg::SERVO_ONE));

  `CPD_ASSERT_NOW(a_full_when_blocked, !s_axis_tready_o, &valid_q, "stall with a bubble")
  `CPD_ASSERT_NEXT(a_accept_enters, s_fire, valid_q[1], "accepted request lost")
  `CPD_ASSERT_NOW(a_pitch_sp_range, m_axis_tvalid_o, psp_ok, "pitch setpoint out of range")
  `CPD_ASSERT_NOW(a_roll_sp_range, m_axis_tvalid_o, rsp_ok, "roll setpoint out of range")
  `CPD_ASSERT_NOW(a_cmd_range, m_axis_tvalid_o, cmd_ok, "servo command not saturated")

endmodule

// File: rtl/cpd_servo.sv
// ----------------------------------------------------------------------------
// cpd_servo
// Inner PD loop: setpoint error times P gain, minus damping product, plus
// trim; rounded to Q1.14, saturated to +-1, optionally negated. 3 stages.
// ----------------------------------------------------------------------------
module cpd_servo #(
  parameter int TRIM   = cpd_pkg::ELEV_OFFSET_DEF,
  parameter int INVERT = cpd_pkg::INVERT_ELEVATOR_DEF
) (
  input  logic                clk_i,
  input  cpd_pkg::servo_en_t  en_i,
  input  logic signed [13:0]  sp_i,      // clamped setpoint, Q3.12
  input  logic signed [15:0]  meas_i,    // measured angle, Q3.12
  input  logic signed [15:0]  kp_i,      // P gain, Q8.8
  input  logic signed [31:0]  d_prod_i,  // D gain times rate
  output logic signed [15:0]  cmd_o,     // servo command, Q1.14
  output logic signed [13:0]  sp_o       // setpoint aligned with cmd_o
);

  localparam logic signed [35:0] TrimTerm = 36'(TRIM * 64 + 32);

  logic signed [16:0] diff_q;
  logic signed [31:0] dprod_a_q, dprod_b_q;
  logic signed [13:0] sp_a_q, sp_b_q, sp_c_q;
  logic signed [32:0] prod_d, prod_q;
  logic signed [35:0] acc;
  logic signed [35:0] shifted;
  logic signed [15:0] sat;
  logic signed [15:0] cmd_d, cmd_q;

  assign prod_d  = 33'(kp_i) * 33'(diff_q);
  assign acc     = 36'(prod_q) - 36'(dprod_b_q) + TrimTerm;
  assign shifted = acc >>> 6;

  always_comb begin
    if (shifted > 36'(cpd_pkg::SERVO_ONE)) begin
      sat = 16'(cpd_pkg::SERVO_ONE);
    end else if (shifted < -36'(cpd_pkg::SERVO_ONE)) begin
      sat = -16'(cpd_pkg::SERVO_ONE);
    end else begin
      sat = shifted[15:0];
    end
    cmd_d = (INVERT > 0) ? sat : -sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff) begin
      diff_q    <= 17'(sp_i) - 17'(meas_i);
      dprod_a_q <= d_prod_i;
      sp_a_q    <= sp_i;
    end
    if (en_i.mult) begin
      prod_q    <= prod_d;
      dprod_b_q <= dprod_a_q;
      sp_b_q    <= sp_a_q;
    end
    if (en_i.sum) begin
      cmd_q     <= cmd_d;
      sp_c_q    <= sp_b_q;
    end
  end

  assign cmd_o = cmd_q;
  assign sp_o  = sp_c_q;

endmodule
